// ===== hdl/counting_sort_histogram_assert.svh =====
// Assertion macros for the counting sort histogram checker.
`ifndef COUNTING_SORT_HISTOGRAM_ASSERT_SVH
`define COUNTING_SORT_HISTOGRAM_ASSERT_SVH

// Clocked assertion, disabled while reset is asserted.
`define CSH_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define CSH_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/cshist_pkg.sv =====
// Types and constants shared by the counting sort histogram modules.
`timescale 1ns / 1ps
package cshist_pkg;

  localparam int VAL_W = 8;
  localparam int BIN_W = 7;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_LOAD,
    ST_DRAIN,
    ST_RD,
    ST_CNT,
    ST_EMIT,
    ST_FIN
  } st_t;

endpackage

// ===== hdl/cshist_ram.sv =====
// Generic simple dual-port RAM, one write port, one registered read port.
`timescale 1ns / 1ps
module cshist_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/counting_sort_histogram.sv =====
// Counting sort: histogram load, ascending readout walk, clear for next set.
// Load: one input word per cycle; each word's bin is read on acceptance, then the
//   s1 stage writes it back incremented. Words past MAX_ITEMS are not counted.
// Readout after the last word: a drain state, then a read and a count state per bin over
//   min(VALUE_RANGE, 256) bins, an emit state per result and a closing state. Bins are zeroed as walked.
// Reset: control state clears, then a clearing pass over all min(VALUE_RANGE, 256)
//   bins zeroes the RAM with in_stall high.
`timescale 1ns / 1ps
module counting_sort_histogram
  import cshist_pkg::*;
#(
  parameter int MAX_ITEMS   = 64,
  parameter int VALUE_RANGE = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [VAL_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [VAL_W-1:0] in_value,
  input  logic             in_last,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [VAL_W-1:0] out_value_res,
  output logic             out_last_res
);

  localparam int DEPTH = (VALUE_RANGE < 256) ? VALUE_RANGE : 256;
  localparam int AW    = $clog2(DEPTH);
  localparam int ICW   = $clog2(MAX_ITEMS + 1);
  localparam logic [AW-1:0]    LAST_BIN = AW'(DEPTH - 1);
  localparam logic [VAL_W-1:0] LAST_VAL = VAL_W'(DEPTH - 1);

  st_t state_r, state_nxt;

  logic [VAL_W-1:0] max_value_r;
  logic [AW-1:0]    b_r, b_nxt;
  logic [BIN_W-1:0] cnt_r, cnt_nxt;
  logic [ICW-1:0]   item_cnt_r, item_cnt_nxt;
  logic             s1_vld_r, s1_vld_nxt;
  logic [AW-1:0]    s1_addr_r, s1_addr_nxt;
  logic             fwd_vld_r;
  logic [AW-1:0]    fwd_addr_r;
  logic [BIN_W-1:0] fwd_data_r;
  logic             pend_vld_r, pend_vld_nxt;
  logic [VAL_W-1:0] pend_val_r, pend_val_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0] out_value_r, out_value_nxt;
  logic             out_last_r, out_last_nxt;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [BIN_W-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [BIN_W-1:0] ram_rdata;

  logic [VAL_W-1:0] top;
  logic [VAL_W-1:0] clamped;
  logic             accept;
  logic             under;
  logic [BIN_W-1:0] s1_cur;
  logic             bin_hit;
  logic             bin_end;
  logic             out_free;
  logic             adv;

  assign top      = (max_value_r > LAST_VAL) ? LAST_VAL : max_value_r;
  assign clamped  = (in_value > top) ? top : in_value;
  assign in_stall = (state_r != ST_LOAD);
  assign accept   = in_valid && !in_stall;
  assign under    = (item_cnt_r < ICW'(MAX_ITEMS));
  assign s1_cur   = (fwd_vld_r && (fwd_addr_r == s1_addr_r)) ? fwd_data_r : ram_rdata;
  assign bin_hit  = (VAL_W'(b_r) <= top) && (ram_rdata != '0);
  assign bin_end  = (b_r == LAST_BIN);
  assign out_free = !out_valid_r || !out_stall;
  assign adv      = !pend_vld_r || out_free;

  assign out_valid     = out_valid_r;
  assign out_value_res = out_value_r;
  assign out_last_res  = out_last_r;

  cshist_ram #(
    .WIDTH (BIN_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLR: begin
        if (bin_end) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (accept && in_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = ST_RD;
      ST_RD:    state_nxt = ST_CNT;
      ST_CNT: begin
        if (bin_hit)      state_nxt = ST_EMIT;
        else if (bin_end) state_nxt = ST_FIN;
        else              state_nxt = ST_RD;
      end
      ST_EMIT: begin
        if (adv && (cnt_r == BIN_W'(1))) state_nxt = bin_end ? ST_FIN : ST_RD;
      end
      ST_FIN: begin
        if (!pend_vld_r || out_free) state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_CLR;
    endcase
  end

  always_comb begin
    b_nxt         = b_r;
    cnt_nxt       = cnt_r;
    item_cnt_nxt  = item_cnt_r;
    pend_vld_nxt  = pend_vld_r;
    pend_val_nxt  = pend_val_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    s1_vld_nxt    = accept && under;
    s1_addr_nxt   = AW'(clamped);
    ram_raddr     = (state_r == ST_LOAD) ? AW'(clamped) : b_r;
    ram_we        = s1_vld_r;
    ram_waddr     = s1_addr_r;
    ram_wdata     = s1_cur + BIN_W'(1);

    if (accept && under) item_cnt_nxt = item_cnt_r + ICW'(1);

    case (state_r)
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = b_r;
        ram_wdata = '0;
        b_nxt     = b_r + AW'(1);
      end
      ST_LOAD: begin
        b_nxt = '0;
      end
      ST_DRAIN: begin
        item_cnt_nxt = '0;
        b_nxt        = '0;
      end
      ST_RD: begin
        b_nxt = b_r;
      end
      ST_CNT: begin
        ram_we    = 1'b1;
        ram_waddr = b_r;
        ram_wdata = '0;
        cnt_nxt   = ram_rdata;
        if (!bin_hit && !bin_end) b_nxt = b_r + AW'(1);
      end
      ST_EMIT: begin
        if (adv) begin
          if (pend_vld_r) begin
            out_valid_nxt = 1'b1;
            out_value_nxt = pend_val_r;
            out_last_nxt  = 1'b0;
          end
          pend_vld_nxt = 1'b1;
          pend_val_nxt = VAL_W'(b_r);
          cnt_nxt      = cnt_r - BIN_W'(1);
          if ((cnt_r == BIN_W'(1)) && !bin_end) b_nxt = b_r + AW'(1);
        end
      end
      ST_FIN: begin
        if (pend_vld_r && out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = pend_val_r;
          out_last_nxt  = 1'b1;
          pend_vld_nxt  = 1'b0;
        end
      end
      default: begin
        b_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      max_value_r <= '1;
      b_r         <= '0;
      item_cnt_r  <= '0;
      s1_vld_r    <= 1'b0;
      fwd_vld_r   <= 1'b0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_wr_en) max_value_r <= cfg_wr_data;
      b_r         <= b_nxt;
      item_cnt_r  <= item_cnt_nxt;
      s1_vld_r    <= s1_vld_nxt;
      fwd_vld_r   <= s1_vld_r;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    s1_addr_r   <= s1_addr_nxt;
    fwd_addr_r  <= s1_addr_r;
    fwd_data_r  <= s1_cur + BIN_W'(1);
    pend_val_r  <= pend_val_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

endmodule

// ===== hdl/cshist_check.sv =====
// Port-level assertion checker for the counting sort histogram, bound to the top level.
`timescale 1ns / 1ps
`include "counting_sort_histogram_assert.svh"
module cshist_check
  import cshist_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             in_last,
  input logic             out_valid,
  input logic             out_stall,
  input logic [VAL_W-1:0] out_value_res,
  input logic             out_last_res
);

  // stalled result word holds
  `CSH_ASSERT(a_out_hold, clk, rst_n, (out_valid && out_stall |=> out_valid && $stable(out_value_res) && $stable(out_last_res)), "stalled result word changed")

  // clearing pass blocks input right after reset
  `CSH_ASSERT_NR(a_rst_stall, clk, (!rst_n |=> in_stall), "input not stalled after reset")

  // last word closes the load phase
  `CSH_ASSERT(a_last_stall, clk, rst_n, (in_valid && !in_stall && in_last |=> in_stall), "input taken after last word")

  // no result word right out of reset
  `CSH_ASSERT_NR(a_rst_idle, clk, (!rst_n |=> !out_valid), "result word valid after reset")

endmodule

bind counting_sort_histogram cshist_check u_cshist_check (.*);
